// File: src/opc_pkg.sv
// opc_pkg: shared types, codes and constants of the opponent pursuit controller
// used by every file of the block through scoped names, depends on nothing

package opc_pkg;

    // config register widths and reset values
    localparam int DIST_W   = 16;
    localparam int LEVEL_W  = 12;
    localparam int TIME_W   = 32;
    localparam int SPEED_W  = 7;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0]  DETECT_DISTANCE_RST = 16'd200;
    localparam logic [LEVEL_W-1:0] EDGE_LEVEL_RST      = 12'd2000;
    localparam logic [TIME_W-1:0]  TRACK_LIMIT_RST     = 32'd800;

    // default depth of the queue between classifier and executor
    localparam int QUEUE_DEPTH = 2;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_DISTANCE = 2'd0,
        CFG_EDGE_LEVEL      = 2'd1,
        CFG_TRACK_LIMIT     = 2'd2
    } t_cfg_idx;

    // operating modes
    typedef enum logic [1:0] {
        MODE_SEARCH   = 2'd0,
        MODE_ATTACK   = 2'd1,
        MODE_TRACKING = 2'd2
    } t_mode;

    // last known opponent direction
    typedef enum logic [1:0] {
        DIR_NONE     = 2'd0,
        DIR_TO_LEFT  = 2'd1,
        DIR_TO_RIGHT = 2'd2,
        DIR_AHEAD    = 2'd3
    } t_dir;

    // motor commands
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_FWD    = 3'd1,
        CMD_SPIN_L = 3'd2,
        CMD_SPIN_R = 3'd3,
        CMD_SIDES  = 3'd4
    } t_cmd;

    // speed settings in percent
    localparam logic [SPEED_W-1:0] SPD_ZERO   = 7'd0;
    localparam logic [SPEED_W-1:0] SPD_SEARCH = 7'd50;
    localparam logic [SPEED_W-1:0] SPD_FULL   = 7'd100;
    localparam logic [SPEED_W-1:0] SPD_SLOW   = 7'd80;
    localparam logic [SPEED_W-1:0] SPD_SPIN   = 7'd90;
    localparam logic [SPEED_W-1:0] SPD_CHASE  = 7'd70;

    // live configuration
    typedef struct packed {
        logic [DIST_W-1:0]  detect_distance;
        logic [LEVEL_W-1:0] edge_level;
        logic [TIME_W-1:0]  track_limit;
    } t_cfg;

    // classified tick as it travels through the queue
    typedef struct packed {
        logic              seen_fr;
        logic              seen_r;
        logic              seen_l;
        logic              seen_fl;
        logic              line_hit;
        logic [TIME_W-1:0] now_ms;
    } t_cls;

endpackage

// File: src/opc_tick_if.sv
// opc_tick_if: input channel carrying one control tick per transaction
// depends on opc_pkg for field widths

interface opc_tick_if;
    logic                         valid;
    logic                         ready;
    logic [opc_pkg::DIST_W-1:0]   dist_front_right;
    logic [opc_pkg::DIST_W-1:0]   dist_right;
    logic [opc_pkg::DIST_W-1:0]   dist_left;
    logic [opc_pkg::DIST_W-1:0]   dist_front_left;
    logic [opc_pkg::LEVEL_W-1:0]  line_left_level;
    logic [opc_pkg::LEVEL_W-1:0]  line_mid_level;
    logic [opc_pkg::LEVEL_W-1:0]  line_right_level;
    logic [opc_pkg::TIME_W-1:0]   now_ms;

    modport source (
        output valid, dist_front_right, dist_right, dist_left, dist_front_left,
               line_left_level, line_mid_level, line_right_level, now_ms,
        input  ready
    );
    modport sink (
        input  valid, dist_front_right, dist_right, dist_left, dist_front_left,
               line_left_level, line_mid_level, line_right_level, now_ms,
        output ready
    );
endinterface

// File: src/opc_result_if.sv
// opc_result_if: output channel carrying one motor decision per transaction
// depends on opc_pkg for field widths

interface opc_result_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   motor_cmd;
    logic [opc_pkg::SPEED_W-1:0]  left_speed;
    logic [opc_pkg::SPEED_W-1:0]  right_speed;
    logic [1:0]                   mode_now;
    logic [1:0]                   direction_now;
    logic                         opponent_seen;

    modport source (
        output valid, motor_cmd, left_speed, right_speed, mode_now,
               direction_now, opponent_seen,
        input  ready
    );
    modport sink (
        input  valid, motor_cmd, left_speed, right_speed, mode_now,
               direction_now, opponent_seen,
        output ready
    );
endinterface

// File: src/opc_front.sv
// opc_front: accepts ticks and reduces the readings to sighting and line flags
// depends on opc_pkg and opc_tick_if

module opc_front (
    opc_tick_if.sink           i_tick,
    input  opc_pkg::t_cfg      i_cfg,
    input  logic               i_q_full,
    output logic               o_q_push,
    output opc_pkg::t_cls      o_q_data
);

    // accept whenever the queue has room
    assign i_tick.ready = !i_q_full;
    assign o_q_push     = i_tick.valid && !i_q_full;

    // range and line level compares
    always_comb begin
        o_q_data.seen_fr  = i_tick.dist_front_right < i_cfg.detect_distance;
        o_q_data.seen_r   = i_tick.dist_right       < i_cfg.detect_distance;
        o_q_data.seen_l   = i_tick.dist_left        < i_cfg.detect_distance;
        o_q_data.seen_fl  = i_tick.dist_front_left  < i_cfg.detect_distance;
        o_q_data.line_hit = (i_tick.line_left_level  > i_cfg.edge_level) ||
                            (i_tick.line_mid_level   > i_cfg.edge_level) ||
                            (i_tick.line_right_level > i_cfg.edge_level);
        o_q_data.now_ms   = i_tick.now_ms;
    end

endmodule

// File: src/opc_queue.sv
// opc_queue: small fifo of classified ticks between front and back
// depends on opc_pkg for the entry type

module opc_queue #(
    parameter int DEPTH = opc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  opc_pkg::t_cls  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output opc_pkg::t_cls  o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    opc_pkg::t_cls r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en, rd_en;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/opc_back.sv
// opc_back: mode machine that turns classified ticks into motor commands
// depends on opc_pkg and opc_result_if; holds the output register

module opc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [opc_pkg::TIME_W-1:0]    i_track_limit,
    input  logic                          i_q_valid,
    input  opc_pkg::t_cls                 i_q_data,
    output logic                          o_q_pop,
    opc_result_if.source                  o_result
);

    opc_pkg::t_mode                   r_mode, n_mode;
    opc_pkg::t_dir                    r_dir, n_dir;
    logic [opc_pkg::TIME_W-1:0]       r_seen_time, n_seen_time;

    logic                             r_out_valid;
    opc_pkg::t_cmd                    r_cmd, n_cmd;
    logic [opc_pkg::SPEED_W-1:0]      r_ls, n_ls, r_rs, n_rs;
    logic                             r_any;

    logic                             any, both_front, timed_out;
    logic [opc_pkg::TIME_W-1:0]       elapsed;

    // take the next tick when the output register is free or being drained
    assign o_q_pop = i_q_valid && (!r_out_valid || o_result.ready);

    assign any        = i_q_data.seen_fr || i_q_data.seen_r ||
                        i_q_data.seen_l  || i_q_data.seen_fl;
    assign both_front = i_q_data.seen_fl && i_q_data.seen_fr;
    assign elapsed    = i_q_data.now_ms - r_seen_time;
    assign timed_out  = elapsed > i_track_limit;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= opc_pkg::MODE_SEARCH;
            r_dir       <= opc_pkg::DIR_NONE;
            r_seen_time <= '0;
        end else if (o_q_pop) begin
            r_mode      <= n_mode;
            r_dir       <= n_dir;
            r_seen_time <= n_seen_time;
        end
    end

    // next state and motor command
    always_comb begin
        n_mode      = r_mode;
        n_dir       = r_dir;
        n_seen_time = r_seen_time;
        n_cmd       = opc_pkg::CMD_HOLD;
        n_ls        = opc_pkg::SPD_ZERO;
        n_rs        = opc_pkg::SPD_ZERO;

        if (i_q_data.line_hit) begin
            n_mode = opc_pkg::MODE_SEARCH;
            n_dir  = opc_pkg::DIR_NONE;
        end else begin
            // remember where the opponent was seen
            if (any) begin
                n_seen_time = i_q_data.now_ms;
                if (both_front) begin
                    n_dir = opc_pkg::DIR_AHEAD;
                end else if (i_q_data.seen_l || i_q_data.seen_fl) begin
                    n_dir = opc_pkg::DIR_TO_LEFT;
                end else begin
                    n_dir = opc_pkg::DIR_TO_RIGHT;
                end
            end

            unique case (r_mode)
                opc_pkg::MODE_ATTACK: begin
                    if (!any) begin
                        n_mode = opc_pkg::MODE_TRACKING;
                    end else if (both_front) begin
                        n_cmd = opc_pkg::CMD_FWD;
                        n_ls  = opc_pkg::SPD_FULL;
                        n_rs  = opc_pkg::SPD_FULL;
                    end else if (i_q_data.seen_fl) begin
                        n_cmd = opc_pkg::CMD_SIDES;
                        n_ls  = opc_pkg::SPD_SLOW;
                        n_rs  = opc_pkg::SPD_FULL;
                    end else if (i_q_data.seen_fr) begin
                        n_cmd = opc_pkg::CMD_SIDES;
                        n_ls  = opc_pkg::SPD_FULL;
                        n_rs  = opc_pkg::SPD_SLOW;
                    end else if (i_q_data.seen_l) begin
                        n_cmd = opc_pkg::CMD_SPIN_L;
                        n_ls  = opc_pkg::SPD_SPIN;
                        n_rs  = opc_pkg::SPD_SPIN;
                    end else begin
                        n_cmd = opc_pkg::CMD_SPIN_R;
                        n_ls  = opc_pkg::SPD_SPIN;
                        n_rs  = opc_pkg::SPD_SPIN;
                    end
                end
                opc_pkg::MODE_TRACKING: begin
                    if (any) begin
                        n_mode = opc_pkg::MODE_ATTACK;
                    end else if (timed_out) begin
                        n_mode = opc_pkg::MODE_SEARCH;
                        n_dir  = opc_pkg::DIR_NONE;
                    end else begin
                        unique case (r_dir)
                            opc_pkg::DIR_TO_LEFT: begin
                                n_cmd = opc_pkg::CMD_SPIN_L;
                                n_ls  = opc_pkg::SPD_SLOW;
                                n_rs  = opc_pkg::SPD_SLOW;
                            end
                            opc_pkg::DIR_TO_RIGHT: begin
                                n_cmd = opc_pkg::CMD_SPIN_R;
                                n_ls  = opc_pkg::SPD_SLOW;
                                n_rs  = opc_pkg::SPD_SLOW;
                            end
                            opc_pkg::DIR_AHEAD: begin
                                n_cmd = opc_pkg::CMD_FWD;
                                n_ls  = opc_pkg::SPD_CHASE;
                                n_rs  = opc_pkg::SPD_CHASE;
                            end
                            default: begin
                                n_mode = opc_pkg::MODE_SEARCH;
                            end
                        endcase
                    end
                end
                default: begin
                    if (any) begin
                        n_mode = opc_pkg::MODE_ATTACK;
                    end else begin
                        n_mode = opc_pkg::MODE_SEARCH;
                        n_cmd  = opc_pkg::CMD_SPIN_R;
                        n_ls   = opc_pkg::SPD_SEARCH;
                        n_rs   = opc_pkg::SPD_SEARCH;
                    end
                end
            endcase
        end
    end

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= n_cmd;
            r_ls  <= n_ls;
            r_rs  <= n_rs;
            r_any <= any;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.motor_cmd     = r_cmd;
    assign o_result.left_speed    = r_ls;
    assign o_result.right_speed   = r_rs;
    assign o_result.mode_now      = r_mode;
    assign o_result.direction_now = r_dir;
    assign o_result.opponent_seen = r_any;

endmodule

// File: src/opponent_pursuit_controller_unit.sv
// opponent_pursuit_controller_unit: top level with config registers and assertions
// depends on opc_pkg, opc_tick_if, opc_result_if, opc_front, opc_queue, opc_back

// Takes one control tick per transaction on i_tick and returns exactly one
// decision per tick on o_result, in order. A tick is accepted every cycle
// while the tick queue has room; it is written to the queue when accepted
// and then loaded into the mode machine's output register once that register
// is free or being drained, and the result is held valid there until taken. The
// sustained rate is one tick per clock while o_result does not stall, as the
// mode, direction and last-sighting registers update once per tick. The
// queue (QUEUE_DEPTH entries) absorbs stalls on o_result until it is full,
// then i_tick.ready drops. Configuration registers (0 detect distance, 1 line
// edge level, 2 tracking time limit) are written through i_cfg_we / i_cfg_idx /
// i_cfg_data and should be changed only while no tick is in flight; writes to
// other indexes are ignored.

module opponent_pursuit_controller_unit #(
    parameter int QUEUE_DEPTH = opc_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [opc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [opc_pkg::CFG_W-1:0]      i_cfg_data,
    opc_tick_if.sink                       i_tick,
    opc_result_if.source                   o_result
);

    opc_pkg::t_cfg r_cfg;
    logic          q_push, q_full, q_pop, q_valid;
    opc_pkg::t_cls q_wr_data, q_rd_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_distance <= opc_pkg::DETECT_DISTANCE_RST;
            r_cfg.edge_level      <= opc_pkg::EDGE_LEVEL_RST;
            r_cfg.track_limit     <= opc_pkg::TRACK_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                opc_pkg::CFG_DETECT_DISTANCE: begin
                    r_cfg.detect_distance <= i_cfg_data[opc_pkg::DIST_W-1:0];
                end
                opc_pkg::CFG_EDGE_LEVEL: begin
                    r_cfg.edge_level <= i_cfg_data[opc_pkg::LEVEL_W-1:0];
                end
                opc_pkg::CFG_TRACK_LIMIT: begin
                    r_cfg.track_limit <= i_cfg_data[opc_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // classifier
    opc_front u_front (
        .i_tick   (i_tick),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wr_data)
    );

    // tick queue
    opc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rd_data)
    );

    // mode machine and output register
    opc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_track_limit (r_cfg.track_limit),
        .i_q_valid     (q_valid),
        .i_q_data      (q_rd_data),
        .o_q_pop       (q_pop),
        .o_result      (o_result)
    );

    // attack mode is only held while the opponent is in sight
    a_attack_needs_sighting: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.mode_now == opc_pkg::MODE_ATTACK)
            |-> o_result.opponent_seen
    ) else $error("attack mode reported without a sighting");

    // tracking always has a known direction to chase
    a_tracking_has_dir: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.mode_now == opc_pkg::MODE_TRACKING)
            |-> (o_result.direction_now != opc_pkg::DIR_NONE)
    ) else $error("tracking mode with unknown direction");

    // hold command carries zero speeds
    a_hold_is_stopped: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.motor_cmd == opc_pkg::CMD_HOLD)
            |-> (o_result.left_speed == '0 && o_result.right_speed == '0)
    ) else $error("hold command with nonzero speed");

    // an accepted tick is always waiting in the queue on the next cycle
    a_push_lands: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        q_push |=> q_valid
    ) else $error("accepted transaction lost before the mode machine");

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for opponent_pursuit_controller_unit
// directed table then random ticks; depends on opc_pkg, the interfaces and the rtl
`timescale 1ns / 1ps

module tb_top;
    import opc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_PHASES = 7;
    localparam int TICKS_PER_PHASE = 240;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [DIST_W-1:0] FAR = 16'hFFFF;
    localparam logic [DIST_W-1:0] NEAR = 16'd0;

    // one control tick as driven on the input channel
    typedef struct packed {
        logic [DIST_W-1:0]  dist_fr;
        logic [DIST_W-1:0]  dist_r;
        logic [DIST_W-1:0]  dist_l;
        logic [DIST_W-1:0]  dist_fl;
        logic [LEVEL_W-1:0] lvl_l;
        logic [LEVEL_W-1:0] lvl_m;
        logic [LEVEL_W-1:0] lvl_r;
        logic [TIME_W-1:0]  now_ms;
    } tick_t;

    // one motor decision as seen on the result channel
    typedef struct packed {
        t_cmd               cmd;
        logic [SPEED_W-1:0] left_spd;
        logic [SPEED_W-1:0] right_spd;
        t_mode              mode;
        t_dir               dir;
        logic               seen;
    } decision_t;

    typedef struct {
        tick_t     tick;
        bit        typed;
        decision_t want;
    } script_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    opc_tick_if   tick_ch ();
    opc_result_if res_ch ();

    opponent_pursuit_controller_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tick     (tick_ch),
        .o_result   (res_ch)
    );

    // predictor copy of the configuration and the pursuit state
    logic [DIST_W-1:0]  cfg_detect;
    logic [LEVEL_W-1:0] cfg_line;
    logic [TIME_W-1:0]  cfg_timeout;
    t_mode              mdl_mode;
    t_dir               mdl_dir;
    logic [TIME_W-1:0]  mdl_seen_ms;

    decision_t   pending_decisions[$];
    script_row_t script[$];
    int          mismatch_count = 0;
    bit          calm = 1'b0;

    // random scene state: running clock and opponent presence
    logic [TIME_W-1:0] clock_ms;
    bit                opp_here = 1'b0;
    int                scene_left = 0;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic decision_t decision_of(t_cmd c, logic [SPEED_W-1:0] ls,
                                              logic [SPEED_W-1:0] rs, t_mode m,
                                              t_dir d, logic s);
        decision_t r;
        r.cmd = c;
        r.left_spd = ls;
        r.right_spd = rs;
        r.mode = m;
        r.dir = d;
        r.seen = s;
        return r;
    endfunction

    // next decision of the controller, advancing the predicted state
    function automatic decision_t predict_decision(tick_t t);
        logic fr, r, l, fl, any, line_hit;
        logic [TIME_W-1:0]  elapsed;
        t_cmd               cmd;
        logic [SPEED_W-1:0] ls, rs;
        fr = t.dist_fr < cfg_detect;
        r  = t.dist_r < cfg_detect;
        l  = t.dist_l < cfg_detect;
        fl = t.dist_fl < cfg_detect;
        any = fr | r | l | fl;
        line_hit = (t.lvl_l > cfg_line) || (t.lvl_m > cfg_line) || (t.lvl_r > cfg_line);
        elapsed = t.now_ms - mdl_seen_ms;
        cmd = CMD_HOLD;
        ls = SPD_ZERO;
        rs = SPD_ZERO;
        if (line_hit) begin
            // arena edge overrides everything, time stamp untouched
            mdl_mode = MODE_SEARCH;
            mdl_dir = DIR_NONE;
        end else begin
            if (any) begin
                mdl_seen_ms = t.now_ms;
                if (fl && fr) mdl_dir = DIR_AHEAD;
                else if (l || fl) mdl_dir = DIR_TO_LEFT;
                else mdl_dir = DIR_TO_RIGHT;
            end
            case (mdl_mode)
                MODE_ATTACK: begin
                    if (!any) begin
                        mdl_mode = MODE_TRACKING;
                    end else if (fl && fr) begin
                        cmd = CMD_FWD; ls = SPD_FULL; rs = SPD_FULL;
                    end else if (fl) begin
                        cmd = CMD_SIDES; ls = SPD_SLOW; rs = SPD_FULL;
                    end else if (fr) begin
                        cmd = CMD_SIDES; ls = SPD_FULL; rs = SPD_SLOW;
                    end else if (l) begin
                        cmd = CMD_SPIN_L; ls = SPD_SPIN; rs = SPD_SPIN;
                    end else begin
                        cmd = CMD_SPIN_R; ls = SPD_SPIN; rs = SPD_SPIN;
                    end
                end
                MODE_TRACKING: begin
                    if (any) begin
                        mdl_mode = MODE_ATTACK;
                    end else if (elapsed > cfg_timeout) begin
                        mdl_mode = MODE_SEARCH;
                        mdl_dir = DIR_NONE;
                    end else if (mdl_dir == DIR_TO_LEFT) begin
                        cmd = CMD_SPIN_L; ls = SPD_SLOW; rs = SPD_SLOW;
                    end else if (mdl_dir == DIR_TO_RIGHT) begin
                        cmd = CMD_SPIN_R; ls = SPD_SLOW; rs = SPD_SLOW;
                    end else if (mdl_dir == DIR_AHEAD) begin
                        cmd = CMD_FWD; ls = SPD_CHASE; rs = SPD_CHASE;
                    end else begin
                        mdl_mode = MODE_SEARCH;
                    end
                end
                default: begin
                    if (any) begin
                        mdl_mode = MODE_ATTACK;
                    end else begin
                        cmd = CMD_SPIN_R; ls = SPD_SEARCH; rs = SPD_SEARCH;
                    end
                end
            endcase
        end
        return decision_of(cmd, ls, rs, mdl_mode, mdl_dir, any);
    endfunction

    function automatic tick_t tick_of(logic [DIST_W-1:0] fr, logic [DIST_W-1:0] r,
                                      logic [DIST_W-1:0] l, logic [DIST_W-1:0] fl,
                                      logic [LEVEL_W-1:0] ll, logic [LEVEL_W-1:0] lm,
                                      logic [LEVEL_W-1:0] lr, logic [TIME_W-1:0] now);
        tick_t t;
        t.dist_fr = fr;
        t.dist_r = r;
        t.dist_l = l;
        t.dist_fl = fl;
        t.lvl_l = ll;
        t.lvl_m = lm;
        t.lvl_r = lr;
        t.now_ms = now;
        return t;
    endfunction

    function automatic void add_row(tick_t t, bit typed, decision_t want);
        script_row_t row;
        row.tick = t;
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endfunction

    // range reading either inside or outside the detect distance
    function automatic logic [DIST_W-1:0] pick_range(bit near);
        if (near && cfg_detect != 0) return DIST_W'($urandom_range(0, cfg_detect - 1));
        case ($urandom_range(0, 9))
            0: return cfg_detect;
            1: return FAR;
            default: return DIST_W'($urandom_range(cfg_detect, 65535));
        endcase
    endfunction

    // line level either over or at most the threshold
    function automatic logic [LEVEL_W-1:0] pick_level(bit over);
        if (over && cfg_line != 12'hFFF) return LEVEL_W'($urandom_range(cfg_line + 1, 4095));
        return LEVEL_W'($urandom_range(0, cfg_line));
    endfunction

    // random tick: opponent comes and goes in bursts, time mostly creeps forward
    function automatic tick_t gen_tick();
        tick_t t;
        int    roll;
        int    edge_at;
        roll = $urandom_range(0, 99);
        if (roll < 3) clock_ms = $urandom;
        else if (roll < 8) clock_ms += TIME_W'($urandom_range(0, 3000));
        else clock_ms += TIME_W'($urandom_range(0, 60));
        if (scene_left == 0) begin
            opp_here = !opp_here;
            scene_left = $urandom_range(1, 30);
        end
        scene_left--;
        t.now_ms = clock_ms;
        t.dist_fr = pick_range(opp_here && $urandom_range(0, 1) == 1);
        t.dist_r  = pick_range(opp_here && $urandom_range(0, 1) == 1);
        t.dist_l  = pick_range(opp_here && $urandom_range(0, 1) == 1);
        t.dist_fl = pick_range(opp_here && $urandom_range(0, 1) == 1);
        edge_at = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 2) : 3;
        t.lvl_l = pick_level(edge_at == 0);
        t.lvl_m = pick_level(edge_at == 1);
        t.lvl_r = pick_level(edge_at == 2);
        // occasional noise tick with every range and level field unconstrained
        if ($urandom_range(0, 99) < 4) begin
            t.dist_fr = DIST_W'($urandom);
            t.dist_r  = DIST_W'($urandom);
            t.dist_l  = DIST_W'($urandom);
            t.dist_fl = DIST_W'($urandom);
            t.lvl_l   = LEVEL_W'($urandom);
            t.lvl_m   = LEVEL_W'($urandom);
            t.lvl_r   = LEVEL_W'($urandom);
        end
        return t;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // drive one tick and record its expected decision once accepted
    task automatic send_tick(tick_t t, bit typed, decision_t want);
        decision_t d;
        while (!calm && $urandom_range(0, 99) < 17) begin
            @(negedge i_clk);
            tick_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        tick_ch.valid            <= 1'b1;
        tick_ch.dist_front_right <= t.dist_fr;
        tick_ch.dist_right       <= t.dist_r;
        tick_ch.dist_left        <= t.dist_l;
        tick_ch.dist_front_left  <= t.dist_fl;
        tick_ch.line_left_level  <= t.lvl_l;
        tick_ch.line_mid_level   <= t.lvl_m;
        tick_ch.line_right_level <= t.lvl_r;
        tick_ch.now_ms           <= t.now_ms;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        d = predict_decision(t);
        pending_decisions.push_back(typed ? want : d);
    endtask

    // stop sending and wait until every decision has come back
    task automatic drain();
        @(negedge i_clk);
        tick_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DETECT_DISTANCE: cfg_detect = data[DIST_W-1:0];
            CFG_EDGE_LEVEL:      cfg_line = data[LEVEL_W-1:0];
            CFG_TRACK_LIMIT:     cfg_timeout = data;
            default: ;  // unused index leaves every register alone
        endcase
    endtask

    // result consumer stalls at random unless in a calm stretch
    always @(negedge i_clk) begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
    end

    // compare each accepted decision against the oldest expectation
    always @(posedge i_clk) begin : result_check
        decision_t want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_decisions.size() == 0) begin
                $error("decision transaction with no tick outstanding");
                mismatch_count++;
            end else begin
                want = pending_decisions.pop_front();
                check_field("motor_cmd", want.cmd, res_ch.motor_cmd);
                check_field("left_speed", want.left_spd, res_ch.left_speed);
                check_field("right_speed", want.right_spd, res_ch.right_speed);
                check_field("mode_now", want.mode, res_ch.mode_now);
                check_field("direction_now", want.dir, res_ch.direction_now);
                check_field("opponent_seen", want.seen, res_ch.opponent_seen);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) || i_cfg_we === 1'b1) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no transaction for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] det, thr, tmo;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        tick_ch.valid            = 1'b0;
        tick_ch.dist_front_right = '0;
        tick_ch.dist_right       = '0;
        tick_ch.dist_left        = '0;
        tick_ch.dist_front_left  = '0;
        tick_ch.line_left_level  = '0;
        tick_ch.line_mid_level   = '0;
        tick_ch.line_right_level = '0;
        tick_ch.now_ms           = '0;
        res_ch.ready             = 1'b0;
        watchdog.quiet_cycles    = 0;
        cfg_detect  = DETECT_DISTANCE_RST;
        cfg_line    = EDGE_LEVEL_RST;
        cfg_timeout = TRACK_LIMIT_RST;
        mdl_mode    = MODE_SEARCH;
        mdl_dir     = DIR_NONE;
        mdl_seen_ms = '0;

        // reset first
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through every mode change at reset configuration
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'd0), 1'b1,
                decision_of(CMD_SPIN_R, SPD_SEARCH, SPD_SEARCH, MODE_SEARCH, DIR_NONE, 1'b0));
        // edge while every sensor sees: hold, sighting still reported
        add_row(tick_of(NEAR, NEAR, NEAR, NEAR, 12'hFFF, 12'd0, 12'd0, 32'd10), 1'b1,
                decision_of(CMD_HOLD, SPD_ZERO, SPD_ZERO, MODE_SEARCH, DIR_NONE, 1'b1));
        // levels exactly at threshold are not an edge
        add_row(tick_of(NEAR, NEAR, NEAR, NEAR, 12'd2000, 12'd2000, 12'd2000, 32'd20),
                1'b0, '0);
        // attack: every steering case
        add_row(tick_of(16'd199, FAR, FAR, 16'd199, 12'd0, 12'd0, 12'd0, 32'd30), 1'b0, '0);
        add_row(tick_of(FAR, FAR, FAR, NEAR, 12'd0, 12'd0, 12'd0, 32'd40), 1'b0, '0);
        add_row(tick_of(NEAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'd50), 1'b0, '0);
        add_row(tick_of(FAR, FAR, NEAR, FAR, 12'd0, 12'd0, 12'd0, 32'd60), 1'b0, '0);
        add_row(tick_of(FAR, NEAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'd70), 1'b0, '0);
        // ranges exactly at detect distance are no sighting: into tracking
        add_row(tick_of(16'd200, 16'd200, 16'd200, 16'd200, 12'd0, 12'd0, 12'd0, 32'd80),
                1'b0, '0);
        // timeout boundary: equal still tracks, one more gives up
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'd870), 1'b0, '0);
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'd871), 1'b0, '0);
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'd900), 1'b0, '0);
        // tracking after a left sighting
        add_row(tick_of(FAR, FAR, NEAR, FAR, 12'd0, 12'd0, 12'd0, 32'd1000), 1'b0, '0);
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'd1001), 1'b0, '0);
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'd1500), 1'b0, '0);
        // tracking after a front sighting
        add_row(tick_of(NEAR, FAR, FAR, NEAR, 12'd0, 12'd0, 12'd0, 32'd1600), 1'b0, '0);
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'd1601), 1'b0, '0);
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'd1700), 1'b0, '0);
        // edge while tracking drops back to search
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd2001, 12'd0, 32'd1800), 1'b1,
                decision_of(CMD_HOLD, SPD_ZERO, SPD_ZERO, MODE_SEARCH, DIR_NONE, 1'b0));
        // elapsed time across the 32-bit wrap
        add_row(tick_of(NEAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'hFFFF_FF00), 1'b0, '0);
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'hFFFF_FF01), 1'b0, '0);
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'd0, 32'h0000_0100), 1'b0, '0);
        add_row(tick_of(FAR, FAR, FAR, FAR, 12'd0, 12'd0, 12'hFFF, 32'hFFFF_FFFF), 1'b1,
                decision_of(CMD_HOLD, SPD_ZERO, SPD_ZERO, MODE_SEARCH, DIR_NONE, 1'b0));
        foreach (script[i]) send_tick(script[i].tick, script[i].typed, script[i].want);

        // random phases, each under its own configuration
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin det = 300;   thr = 1500; tmo = 500; end
                1: begin det = 0;     thr = 4095; tmo = 0; end
                2: begin det = 65535; thr = 0;    tmo = 32'hFFFF_FFFF; end
                3: begin
                    det = $urandom_range(0, 65535);
                    thr = $urandom_range(0, 4095);
                    tmo = $urandom_range(0, 3000);
                end
                4: begin det = 1000;  thr = 3000; tmo = 100; end
                5: begin det = $urandom_range(0, 65535); thr = $urandom_range(0, 4095);
                         tmo = $urandom; end
                default: begin det = 200; thr = 2000; tmo = 800; end
            endcase
            cfg_write(CFG_DETECT_DISTANCE, det);
            cfg_write(CFG_EDGE_LEVEL, thr);
            cfg_write(CFG_TRACK_LIMIT, tmo);
            cfg_write(CFG_IDX_SPARE, $urandom);
            clock_ms = (ph % 2 == 1) ? 32'hFFFF_FC00 : $urandom;
            // one phase runs with both sides streaming back to back
            calm = (ph == 4);
            repeat (TICKS_PER_PHASE) send_tick(gen_tick(), 1'b0, '0);
        end
        calm = 1'b0;
        drain();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
src/opc_pkg.sv
src/opc_tick_if.sv
src/opc_result_if.sv
src/opc_front.sv
src/opc_queue.sv
src/opc_back.sv
src/opponent_pursuit_controller_unit.sv
bench/tb_top.sv
